@@ sv/refpfa_pkg.sv @@
package refpfa_pkg;

  localparam int ADDR_W   = 21;
  localparam int SIZE_W   = 16;
  localparam int CNT_W    = 8;
  localparam int BOUND_W  = 10;
  localparam int CONS_W   = 9;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_SHARE = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOMEM = 2'd1,
    ST_UNREF = 2'd2,
    ST_ALIGN = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_RESERVED = 2'd0,
    REG_HOLE_LO  = 2'd1,
    REG_HOLE_HI  = 2'd2,
    REG_CONSOLE  = 2'd3
  } reg_idx_t;

  localparam logic [BOUND_W-1:0] RESERVED_RST = BOUND_W'(1);
  localparam logic [BOUND_W-1:0] HOLE_LO_RST  = BOUND_W'(160);
  localparam logic [BOUND_W-1:0] HOLE_HI_RST  = BOUND_W'(256);
  localparam logic [CONS_W-1:0]  CONSOLE_RST  = CONS_W'(184);

endpackage

@@ sv/refcounted_page_frame_allocator.sv @@
// Reference-counted first-fit page frame allocator.
// Input channel: drive start with in_req_type, in_alloc_size and in_address;
// the transaction is taken on a clock edge where start is high and busy low.
// Allocate returns the lowest allocatable page with a zero count and sets
// its count to one; free decrements, share increments (saturating at 255).
// Result channel: out_valid is high for exactly one cycle with out_status,
// out_result_address and out_new_count; the receiver cannot stall it.
// Free and share read the page's count at the accepting edge, then update it
// in S_UPD as the result is registered; free of address zero, free or share
// past NUM_PAGES, an oversize allocate and unused request types register their
// result at the accepting edge. Allocate walks the count memory one page per
// cycle through a single compare unit, until a page is found or none is left.
// One transaction at a time: busy stays high until the result is issued, and
// the next transaction can be taken at the edge that takes the result.
// Reset: configuration registers take their defaults and the count memory is
// swept to zero, one entry per cycle, while busy is high.
// Configuration registers are written over the APB port at byte offsets
// 0, 4, 8 and 12 and should only be changed while the block is idle.
// PAGE_BYTES must be a power of two.
module refcounted_page_frame_allocator #(
  parameter int NUM_PAGES  = 512,
  parameter int PAGE_BYTES = 4096
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            in_req_type,
  input  logic [refpfa_pkg::SIZE_W-1:0]         in_alloc_size,
  input  logic [refpfa_pkg::ADDR_W-1:0]         in_address,
  output logic                                  out_valid,
  output logic [1:0]                            out_status,
  output logic [refpfa_pkg::ADDR_W-1:0]         out_result_address,
  output logic [refpfa_pkg::CNT_W-1:0]          out_new_count,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [refpfa_pkg::APB_AW-1:0]         paddr,
  input  logic [refpfa_pkg::APB_DW-1:0]         pwdata,
  output logic [refpfa_pkg::APB_DW-1:0]         prdata,
  output logic                                  pready
);

  localparam int ADDR_W = refpfa_pkg::ADDR_W;
  localparam int CNT_W  = refpfa_pkg::CNT_W;
  localparam int OFF_W  = $clog2(PAGE_BYTES);
  localparam int PNO_W  = ADDR_W - OFF_W;
  localparam int IDX_W  = (NUM_PAGES > 2) ? $clog2(NUM_PAGES) : 1;
  localparam int CNTR_W = IDX_W + 1;
  localparam int MW1    = (IDX_W > refpfa_pkg::BOUND_W) ? IDX_W : refpfa_pkg::BOUND_W;
  localparam int MW2    = (MW1 > PNO_W) ? MW1 : PNO_W;
  localparam int CW     = MW2 + 1;

  typedef enum logic [3:0] {
    S_CLR  = 4'b0001,
    S_IDLE = 4'b0010,
    S_SCAN = 4'b0100,
    S_UPD  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [refpfa_pkg::BOUND_W-1:0] reserved_r, hole_lo_r, hole_hi_r;
  logic [refpfa_pkg::CONS_W-1:0]  console_r;

  logic [CNT_W-1:0] mem [NUM_PAGES];
  logic [CNT_W-1:0] rdata_r;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic [CNT_W-1:0] wr_data;
  logic             wr_en;

  logic [CNTR_W-1:0] cnt_r, cnt_nxt;
  logic              chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]  chk_p_r, chk_p_nxt;
  logic [IDX_W-1:0]  page_r, page_nxt;
  logic              is_share_r, is_share_nxt;
  logic              off_nz_r, off_nz_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          out_status_r, out_status_nxt;
  logic [ADDR_W-1:0]   out_addr_r, out_addr_nxt;
  logic [CNT_W-1:0]    out_cnt_r, out_cnt_nxt;

  logic [CW-1:0]    in_pno;
  logic             in_range, in_off_nz, accept, issue, alloc_ok, found;
  logic [CW-1:0]    p_cw;
  logic             cfg_wr;

  // configuration
  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reserved_r <= refpfa_pkg::RESERVED_RST;
      hole_lo_r  <= refpfa_pkg::HOLE_LO_RST;
      hole_hi_r  <= refpfa_pkg::HOLE_HI_RST;
      console_r  <= refpfa_pkg::CONSOLE_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        refpfa_pkg::REG_RESERVED: reserved_r <= pwdata[refpfa_pkg::BOUND_W-1:0];
        refpfa_pkg::REG_HOLE_LO:  hole_lo_r  <= pwdata[refpfa_pkg::BOUND_W-1:0];
        refpfa_pkg::REG_HOLE_HI:  hole_hi_r  <= pwdata[refpfa_pkg::BOUND_W-1:0];
        refpfa_pkg::REG_CONSOLE:  console_r  <= pwdata[refpfa_pkg::CONS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      refpfa_pkg::REG_RESERVED: prdata = refpfa_pkg::APB_DW'(reserved_r);
      refpfa_pkg::REG_HOLE_LO:  prdata = refpfa_pkg::APB_DW'(hole_lo_r);
      refpfa_pkg::REG_HOLE_HI:  prdata = refpfa_pkg::APB_DW'(hole_hi_r);
      refpfa_pkg::REG_CONSOLE:  prdata = refpfa_pkg::APB_DW'(console_r);
      default:                  prdata = '0;
    endcase
  end

  // request decode
  assign in_pno    = CW'(in_address[ADDR_W-1:OFF_W]);
  assign in_range  = in_pno < CW'(NUM_PAGES);
  assign in_off_nz = |in_address[OFF_W-1:0];
  assign busy      = (state_r != S_IDLE);
  assign accept    = start & ~busy;

  // shared compare unit for the first-fit walk
  assign issue    = cnt_r < CNTR_W'(NUM_PAGES);
  assign p_cw     = CW'(chk_p_r);
  assign alloc_ok = (p_cw < (CW'(1) << PNO_W)) &&
                    (p_cw >= CW'(reserved_r)) &&
                    !((p_cw >= CW'(hole_lo_r)) && (p_cw < CW'(hole_hi_r))) &&
                    (p_cw != CW'(console_r));
  assign found    = chk_vld_r && alloc_ok && (rdata_r == '0);

  // count memory
  assign rd_addr = (state_r == S_IDLE) ? in_pno[IDX_W-1:0] : cnt_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    rdata_r <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    chk_vld_nxt    = 1'b0;
    chk_p_nxt      = chk_p_r;
    page_nxt       = page_r;
    is_share_nxt   = is_share_r;
    off_nz_nxt     = off_nz_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_cnt_nxt    = out_cnt_r;
    wr_en          = 1'b0;
    wr_addr        = cnt_r[IDX_W-1:0];
    wr_data        = '0;

    case (state_r)
      S_CLR: begin
        wr_en   = 1'b1;
        cnt_nxt = cnt_r + CNTR_W'(1);
        if (cnt_r == CNTR_W'(NUM_PAGES - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          page_nxt       = in_pno[IDX_W-1:0];
          is_share_nxt   = (in_req_type == refpfa_pkg::REQ_SHARE);
          off_nz_nxt     = in_off_nz;
          out_status_nxt = refpfa_pkg::ST_OK;
          out_addr_nxt   = '0;
          out_cnt_nxt    = '0;
          case (in_req_type)
            refpfa_pkg::REQ_ALLOC: begin
              if ({1'b0, in_alloc_size} > (refpfa_pkg::SIZE_W + 1)'(PAGE_BYTES)) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = refpfa_pkg::ST_NOMEM;
              end else begin
                cnt_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end
            refpfa_pkg::REQ_FREE: begin
              if (in_address == '0) begin
                out_valid_nxt = 1'b1;
              end else if (!in_range) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = refpfa_pkg::ST_UNREF;
              end else begin
                state_nxt = S_UPD;
              end
            end
            refpfa_pkg::REQ_SHARE: begin
              if (!in_range) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = refpfa_pkg::ST_UNREF;
              end else begin
                state_nxt = S_UPD;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (issue) begin
          cnt_nxt     = cnt_r + CNTR_W'(1);
          chk_vld_nxt = 1'b1;
          chk_p_nxt   = cnt_r[IDX_W-1:0];
        end
        if (found) begin
          wr_en          = 1'b1;
          wr_addr        = chk_p_r;
          wr_data        = CNT_W'(1);
          out_valid_nxt  = 1'b1;
          out_status_nxt = refpfa_pkg::ST_OK;
          out_addr_nxt   = ADDR_W'(chk_p_r) << OFF_W;
          out_cnt_nxt    = CNT_W'(1);
          chk_vld_nxt    = 1'b0;
          state_nxt      = S_IDLE;
        end else if (!chk_vld_r && !issue) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = refpfa_pkg::ST_NOMEM;
          state_nxt      = S_IDLE;
        end
      end

      S_UPD: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        wr_addr       = page_r;
        if (!is_share_r && rdata_r == '0) begin
          out_status_nxt = refpfa_pkg::ST_UNREF;
          out_cnt_nxt    = '0;
        end else if (off_nz_r) begin
          out_status_nxt = refpfa_pkg::ST_ALIGN;
          out_cnt_nxt    = rdata_r;
        end else if (is_share_r) begin
          wr_en          = 1'b1;
          wr_data        = (rdata_r == '1) ? rdata_r : rdata_r + CNT_W'(1);
          out_status_nxt = refpfa_pkg::ST_OK;
          out_cnt_nxt    = wr_data;
        end else begin
          wr_en          = 1'b1;
          wr_data        = rdata_r - CNT_W'(1);
          out_status_nxt = refpfa_pkg::ST_OK;
          out_cnt_nxt    = wr_data;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      cnt_r       <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_p_r      <= chk_p_nxt;
    page_r       <= page_nxt;
    is_share_r   <= is_share_nxt;
    off_nz_r     <= off_nz_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_result_address = out_addr_r;
  assign out_new_count      = out_cnt_r;

endmodule

@@ bench/refcounted_page_frame_allocator_checker.sv @@
module refcounted_page_frame_allocator_checker #(
  parameter int NUM_PAGES  = 512,
  parameter int PAGE_BYTES = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic [1:0]                    in_req_type,
  input  logic [refpfa_pkg::SIZE_W-1:0] in_alloc_size,
  input  logic [refpfa_pkg::ADDR_W-1:0] in_address,
  input  logic                          out_valid,
  input  logic [1:0]                    out_status,
  input  logic [refpfa_pkg::ADDR_W-1:0] out_result_address,
  input  logic [refpfa_pkg::CNT_W-1:0]  out_new_count,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [refpfa_pkg::APB_AW-1:0] paddr,
  input  logic [refpfa_pkg::APB_DW-1:0] pwdata,
  input  logic [refpfa_pkg::APB_DW-1:0] prdata,
  input  logic                          pready,
  output int                            fail_count,
  output int                            pending
);

  localparam int ADDR_W  = refpfa_pkg::ADDR_W;
  localparam int SIZE_W  = refpfa_pkg::SIZE_W;
  localparam int CNT_W   = refpfa_pkg::CNT_W;
  localparam int BOUND_W = refpfa_pkg::BOUND_W;
  localparam int CONS_W  = refpfa_pkg::CONS_W;
  localparam int APB_DW  = refpfa_pkg::APB_DW;

  typedef struct packed {
    refpfa_pkg::status_t status;
    logic [ADDR_W-1:0]   addr;
    logic [CNT_W-1:0]    count;
  } frame_result_t;

  logic [CNT_W-1:0]   refcount [NUM_PAGES];
  logic [BOUND_W-1:0] reserved_below;
  logic [BOUND_W-1:0] hole_lo;
  logic [BOUND_W-1:0] hole_hi;
  logic [CONS_W-1:0]  console;
  frame_result_t      frame_results_q [$];
  int                 errors;
  int                 n_results;

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    if (errors <= 200)
      $display("mismatch #%0d (transaction %0d): %s got %0h wanted %0h",
               errors, n_results, what, got, want);
  endtask

  function automatic bit page_usable(int p);
    longint byte_addr;
    byte_addr = longint'(p) * PAGE_BYTES;
    if (byte_addr > ((longint'(1) << ADDR_W) - 1)) return 1'b0;
    if (p < int'(reserved_below)) return 1'b0;
    if (p >= int'(hole_lo) && p < int'(hole_hi)) return 1'b0;
    if (p == int'(console)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic frame_result_t serve_request(refpfa_pkg::req_t req,
                                                  logic [SIZE_W-1:0] size,
                                                  logic [ADDR_W-1:0] addr);
    frame_result_t r;
    longint        pno;
    longint        off;
    r = '{status: refpfa_pkg::ST_OK, addr: '0, count: '0};
    pno = longint'(addr) / PAGE_BYTES;
    off = longint'(addr) % PAGE_BYTES;
    case (req)
      refpfa_pkg::REQ_ALLOC: begin
        r.status = refpfa_pkg::ST_NOMEM;
        if (int'(size) <= PAGE_BYTES) begin
          for (int p = 0; p < NUM_PAGES; p++) begin
            if (page_usable(p) && refcount[p] == '0) begin
              refcount[p] = CNT_W'(1);
              r.status = refpfa_pkg::ST_OK;
              r.addr = ADDR_W'(longint'(p) * PAGE_BYTES);
              r.count = CNT_W'(1);
              break;
            end
          end
        end
      end
      refpfa_pkg::REQ_FREE: begin
        if (addr == '0) begin
          // address zero is ignored
        end else if (pno >= NUM_PAGES || refcount[pno] == '0) begin
          r.status = refpfa_pkg::ST_UNREF;
        end else if (off != 0) begin
          r.status = refpfa_pkg::ST_ALIGN;
          r.count = refcount[pno];
        end else begin
          refcount[pno] = refcount[pno] - CNT_W'(1);
          r.count = refcount[pno];
        end
      end
      refpfa_pkg::REQ_SHARE: begin
        if (pno >= NUM_PAGES) begin
          r.status = refpfa_pkg::ST_UNREF;
        end else if (off != 0) begin
          r.status = refpfa_pkg::ST_ALIGN;
          r.count = refcount[pno];
        end else begin
          if (refcount[pno] != '1) refcount[pno] = refcount[pno] + CNT_W'(1);
          r.count = refcount[pno];
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic logic [APB_DW-1:0] reg_value(refpfa_pkg::reg_idx_t idx);
    case (idx)
      refpfa_pkg::REG_RESERVED: return APB_DW'(reserved_below);
      refpfa_pkg::REG_HOLE_LO:  return APB_DW'(hole_lo);
      refpfa_pkg::REG_HOLE_HI:  return APB_DW'(hole_hi);
      default:                  return APB_DW'(console);
    endcase
  endfunction

  always @(posedge clk) begin
    frame_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_PAGES; i++) refcount[i] = '0;
      reserved_below = refpfa_pkg::RESERVED_RST;
      hole_lo = refpfa_pkg::HOLE_LO_RST;
      hole_hi = refpfa_pkg::HOLE_HI_RST;
      console = refpfa_pkg::CONSOLE_RST;
      frame_results_q.delete();
    end else begin
      if (out_valid) begin
        if (frame_results_q.size() == 0) begin
          report_mismatch("result with nothing outstanding, status", out_status, 0);
        end else begin
          want = frame_results_q.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", out_status, want.status);
          if (out_result_address !== want.addr)
            report_mismatch("result_address", out_result_address, want.addr);
          if (out_new_count !== want.count)
            report_mismatch("new_count", out_new_count, want.count);
        end
        n_results++;
      end
      if (start && !busy)
        frame_results_q.push_back(serve_request(refpfa_pkg::req_t'(in_req_type),
                                                in_alloc_size, in_address));
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (refpfa_pkg::reg_idx_t'(paddr[3:2]))
            refpfa_pkg::REG_RESERVED: reserved_below = pwdata[BOUND_W-1:0];
            refpfa_pkg::REG_HOLE_LO:  hole_lo = pwdata[BOUND_W-1:0];
            refpfa_pkg::REG_HOLE_HI:  hole_hi = pwdata[BOUND_W-1:0];
            default:                  console = pwdata[CONS_W-1:0];
          endcase
        end else if (prdata !== reg_value(refpfa_pkg::reg_idx_t'(paddr[3:2]))) begin
          report_mismatch("register readback", prdata,
                          reg_value(refpfa_pkg::reg_idx_t'(paddr[3:2])));
        end
      end
    end
    pending <= frame_results_q.size();
    fail_count <= errors;
  end

endmodule

@@ bench/refcounted_page_frame_allocator_test.sv @@
module refcounted_page_frame_allocator_test;

  localparam int NUM_PAGES    = 512;
  localparam int PAGE_BYTES   = 4096;
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int DRAIN_CYCLES = NUM_PAGES + 16;
  localparam int ADDR_W       = refpfa_pkg::ADDR_W;
  localparam int SIZE_W       = refpfa_pkg::SIZE_W;
  localparam int CNT_W        = refpfa_pkg::CNT_W;
  localparam int APB_AW       = refpfa_pkg::APB_AW;
  localparam int APB_DW       = refpfa_pkg::APB_DW;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic [1:0]        in_req_type = '0;
  logic [SIZE_W-1:0] in_alloc_size = '0;
  logic [ADDR_W-1:0] in_address = '0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;

  logic              busy;
  logic              out_valid;
  logic [1:0]        out_status;
  logic [ADDR_W-1:0] out_result_address;
  logic [CNT_W-1:0]  out_new_count;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int fail_count;
  int pending;
  int cycle_count = 0;
  bit quiet = 1'b0;

  refcounted_page_frame_allocator #(
    .NUM_PAGES (NUM_PAGES),
    .PAGE_BYTES(PAGE_BYTES)
  ) u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_alloc_size(in_alloc_size), .in_address(in_address),
    .out_valid(out_valid), .out_status(out_status),
    .out_result_address(out_result_address), .out_new_count(out_new_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  refcounted_page_frame_allocator_checker #(
    .NUM_PAGES (NUM_PAGES),
    .PAGE_BYTES(PAGE_BYTES)
  ) u_check (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_alloc_size(in_alloc_size), .in_address(in_address),
    .out_valid(out_valid), .out_status(out_status),
    .out_result_address(out_result_address), .out_new_count(out_new_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  task automatic idle_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) n = 0;
    else if (r < 90) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // returns at the edge where the transaction is taken
  task automatic issue(refpfa_pkg::req_t req, logic [SIZE_W-1:0] size,
                       logic [ADDR_W-1:0] addr);
    idle_gap();
    start <= 1'b1;
    in_req_type <= req;
    in_alloc_size <= size;
    in_address <= addr;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
  endtask

  task automatic apb_transfer(bit wr, refpfa_pkg::reg_idx_t idx, int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= APB_AW'({idx, 2'b00});
    pwdata <= APB_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(int res, int lo, int hi, int cons);
    drain();
    apb_transfer(1'b1, refpfa_pkg::REG_RESERVED, res);
    apb_transfer(1'b1, refpfa_pkg::REG_HOLE_LO, lo);
    apb_transfer(1'b1, refpfa_pkg::REG_HOLE_HI, hi);
    apb_transfer(1'b1, refpfa_pkg::REG_CONSOLE, cons);
    apb_transfer(1'b0, refpfa_pkg::REG_RESERVED, 0);
    apb_transfer(1'b0, refpfa_pkg::REG_HOLE_LO, 0);
    apb_transfer(1'b0, refpfa_pkg::REG_HOLE_HI, 0);
    apb_transfer(1'b0, refpfa_pkg::REG_CONSOLE, 0);
  endtask

  // frees and shares aim at the pages where allocations land
  task automatic random_request(int focus);
    int                r;
    int                s;
    int                page;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
    r = $urandom_range(0, 99);
    size = SIZE_W'($urandom);
    addr = ADDR_W'($urandom);
    page = (focus + $urandom_range(0, 15)) % NUM_PAGES;
    if (r < 40) begin
      if ($urandom_range(0, 9) != 0) size = SIZE_W'($urandom_range(0, PAGE_BYTES));
      issue(refpfa_pkg::REQ_ALLOC, size, addr);
    end else if (r < 95) begin
      s = $urandom_range(0, 19);
      if (s < 15) addr = ADDR_W'(page * PAGE_BYTES);
      else if (s < 17) addr = ADDR_W'(page * PAGE_BYTES + $urandom_range(1, PAGE_BYTES - 1));
      else if (s == 17) addr = '0;
      issue((r < 70) ? refpfa_pkg::REQ_FREE : refpfa_pkg::REQ_SHARE, size, addr);
    end else begin
      issue(refpfa_pkg::REQ_NONE, size, addr);
    end
  endtask

  task automatic run_phase(int res, int lo, int hi, int cons, int n_items, int focus);
    configure(res, lo, hi, cons);
    quiet = ($urandom_range(0, 3) == 0);
    repeat (n_items) random_request(focus);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (busy);

    // reset configuration, clean count table
    issue(refpfa_pkg::REQ_ALLOC, 16'd0, '0);
    issue(refpfa_pkg::REQ_ALLOC, 16'd4096, '1);
    issue(refpfa_pkg::REQ_ALLOC, 16'd4097, '0);
    issue(refpfa_pkg::REQ_ALLOC, '1, '0);
    issue(refpfa_pkg::REQ_FREE, '1, '0);
    issue(refpfa_pkg::REQ_FREE, '0, 21'h001000);
    issue(refpfa_pkg::REQ_FREE, '0, 21'h001000);
    issue(refpfa_pkg::REQ_SHARE, '0, 21'h002000);
    issue(refpfa_pkg::REQ_SHARE, '0, 21'h002001);
    issue(refpfa_pkg::REQ_FREE, '0, 21'h002FFF);
    issue(refpfa_pkg::REQ_FREE, '0, 21'h1FFFFF);
    issue(refpfa_pkg::REQ_SHARE, '0, 21'h1FF000);
    issue(refpfa_pkg::REQ_FREE, '0, 21'h1FF001);
    issue(refpfa_pkg::REQ_SHARE, '0, '0);
    issue(refpfa_pkg::REQ_FREE, '0, '0);
    issue(refpfa_pkg::REQ_NONE, '1, '1);
    issue(refpfa_pkg::REQ_NONE, '0, '0);
    issue(refpfa_pkg::REQ_ALLOC, 16'd1, '0);
    issue(refpfa_pkg::REQ_SHARE, '0, 21'h0A0000);
    issue(refpfa_pkg::REQ_FREE, '0, 21'h0A0000);
    drain();
    apb_transfer(1'b0, refpfa_pkg::REG_RESERVED, 0);
    apb_transfer(1'b0, refpfa_pkg::REG_HOLE_LO, 0);
    apb_transfer(1'b0, refpfa_pkg::REG_HOLE_HI, 0);
    apb_transfer(1'b0, refpfa_pkg::REG_CONSOLE, 0);

    // drive one page into saturation and back down
    quiet = 1'b1;
    repeat (258) issue(refpfa_pkg::REQ_SHARE, SIZE_W'($urandom), 21'h007000);
    quiet = 1'b0;
    issue(refpfa_pkg::REQ_SHARE, '0, 21'h007800);
    repeat (4) issue(refpfa_pkg::REQ_FREE, SIZE_W'($urandom), 21'h007000);

    run_phase(1, 160, 256, 184, 300, 1);
    run_phase(0, 512, 0, 511, 200, 0);
    run_phase(1, 9, 512, 3, 300, 0);
    run_phase(512, 0, 512, 0, 50, 0);
    run_phase(0, 0, 512, 0, 40, 0);
    run_phase(0, 0, 0, 0, 200, 0);
    run_phase(500, 0, 0, 505, 40, 500);
    repeat (3) begin
      int res;
      res = $urandom_range(0, 32);
      run_phase(res, $urandom_range(0, 512), $urandom_range(0, 512),
                $urandom_range(0, 511), 150, res);
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
